/* sv/luv_pkg.sv */
// ----------------------------------------------------------------------------
// luv_pkg: shared definitions for the lens undistortion point unit
// Types, codes, fixed-point helpers and the micro-op program that the
// sequencer steps through.
// ----------------------------------------------------------------------------
`default_nettype none

package luv_pkg;

  localparam int DEF_MAX_ITERATIONS = 20;
  localparam int TOLERANCE_LSB      = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [31:0] RST_INV_FOCAL_X = 32'd8589934;
  localparam logic [31:0] RST_INV_FOCAL_Y = 32'd8589934;
  localparam logic [15:0] RST_CENTER_X    = 16'd5120;
  localparam logic [15:0] RST_CENTER_Y    = 16'd3840;

  // 1.0 in Q4.28.
  localparam logic [31:0] Q_ONE = 32'h1000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_RADIAL_K1   = 3'd4,
    REG_RADIAL_K2   = 3'd5,
    REG_RADIAL_K3   = 3'd6,
    REG_TANGENTIAL  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_SCALE
  } alu_op_e;

  // Operand and destination slots of the datapath.
  typedef enum logic [4:0] {
    OPD_X, OPD_Y, OPD_XD, OPD_YD, OPD_XX, OPD_YY, OPD_R2, OPD_R4,
    OPD_R6, OPD_XY2, OPD_RC, OPD_FX, OPD_FY, OPD_T, OPD_DX, OPD_DY,
    OPD_K1, OPD_K2, OPD_K3, OPD_P1, OPD_P2, OPD_ONE, OPD_ZERO,
    OPD_PU, OPD_PV, OPD_CX, OPD_CY, OPD_IFX, OPD_IFY
  } opnd_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_ISSUE,
    SEQ_MUL,
    SEQ_CHECK,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    alu_op_e op;
    opnd_e   a;
    opnd_e   b;
    opnd_e   dst;
  } uop_t;

  typedef struct packed {
    logic    busy;
    logic    we;
    logic    mul_go;
    logic    wb_mul;
    alu_op_e alu_op;
    opnd_e   src_a;
    opnd_e   src_b;
    opnd_e   dst;
    logic    out_load;
    logic    out_conv;
  } luv_ctrl_t;

  localparam int                PC_W       = 6;
  localparam logic [PC_W-1:0]   PROG_LOOP  = 6'd6;
  localparam logic [PC_W-1:0]   PROG_LAST  = 6'd36;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat66(input logic [65:0] v);
    logic [31:0] r;
    if ((&v[65:31]) || (~|v[65:31])) begin
      r = v[31:0];
    end else begin
      r = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Setup: shift and scale the pixel, seed the estimate. Then one iteration
  // of the forward distortion and the residual update from PROG_LOOP on.
  function automatic uop_t prog_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:    u = '{ALU_SUB,   OPD_PU,  OPD_CX,   OPD_XD};
      6'd1:    u = '{ALU_SUB,   OPD_PV,  OPD_CY,   OPD_YD};
      6'd2:    u = '{ALU_SCALE, OPD_XD,  OPD_IFX,  OPD_XD};
      6'd3:    u = '{ALU_SCALE, OPD_YD,  OPD_IFY,  OPD_YD};
      6'd4:    u = '{ALU_ADD,   OPD_XD,  OPD_ZERO, OPD_X};
      6'd5:    u = '{ALU_ADD,   OPD_YD,  OPD_ZERO, OPD_Y};
      6'd6:    u = '{ALU_MUL,   OPD_X,   OPD_X,    OPD_XX};
      6'd7:    u = '{ALU_MUL,   OPD_Y,   OPD_Y,    OPD_YY};
      6'd8:    u = '{ALU_ADD,   OPD_XX,  OPD_YY,   OPD_R2};
      6'd9:    u = '{ALU_MUL,   OPD_R2,  OPD_R2,   OPD_R4};
      6'd10:   u = '{ALU_MUL,   OPD_R4,  OPD_R2,   OPD_R6};
      6'd11:   u = '{ALU_MUL,   OPD_X,   OPD_Y,    OPD_T};
      6'd12:   u = '{ALU_ADD,   OPD_T,   OPD_T,    OPD_XY2};
      6'd13:   u = '{ALU_MUL,   OPD_K1,  OPD_R2,   OPD_T};
      6'd14:   u = '{ALU_ADD,   OPD_ONE, OPD_T,    OPD_RC};
      6'd15:   u = '{ALU_MUL,   OPD_K2,  OPD_R4,   OPD_T};
      6'd16:   u = '{ALU_ADD,   OPD_RC,  OPD_T,    OPD_RC};
      6'd17:   u = '{ALU_MUL,   OPD_K3,  OPD_R6,   OPD_T};
      6'd18:   u = '{ALU_ADD,   OPD_RC,  OPD_T,    OPD_RC};
      6'd19:   u = '{ALU_MUL,   OPD_X,   OPD_RC,   OPD_FX};
      6'd20:   u = '{ALU_MUL,   OPD_P1,  OPD_XY2,  OPD_T};
      6'd21:   u = '{ALU_ADD,   OPD_FX,  OPD_T,    OPD_FX};
      6'd22:   u = '{ALU_ADD,   OPD_XX,  OPD_XX,   OPD_T};
      6'd23:   u = '{ALU_ADD,   OPD_R2,  OPD_T,    OPD_T};
      6'd24:   u = '{ALU_MUL,   OPD_P2,  OPD_T,    OPD_T};
      6'd25:   u = '{ALU_ADD,   OPD_FX,  OPD_T,    OPD_FX};
      6'd26:   u = '{ALU_MUL,   OPD_Y,   OPD_RC,   OPD_FY};
      6'd27:   u = '{ALU_ADD,   OPD_YY,  OPD_YY,   OPD_T};
      6'd28:   u = '{ALU_ADD,   OPD_R2,  OPD_T,    OPD_T};
      6'd29:   u = '{ALU_MUL,   OPD_P1,  OPD_T,    OPD_T};
      6'd30:   u = '{ALU_ADD,   OPD_FY,  OPD_T,    OPD_FY};
      6'd31:   u = '{ALU_MUL,   OPD_P2,  OPD_XY2,  OPD_T};
      6'd32:   u = '{ALU_ADD,   OPD_FY,  OPD_T,    OPD_FY};
      6'd33:   u = '{ALU_SUB,   OPD_XD,  OPD_FX,   OPD_DX};
      6'd34:   u = '{ALU_SUB,   OPD_YD,  OPD_FY,   OPD_DY};
      6'd35:   u = '{ALU_ADD,   OPD_X,   OPD_DX,   OPD_X};
      6'd36:   u = '{ALU_ADD,   OPD_Y,   OPD_DY,   OPD_Y};
      default: u = '{ALU_ADD,   OPD_ZERO, OPD_ZERO, OPD_T};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* sv/luv_alu.sv */
// ----------------------------------------------------------------------------
// luv_alu: shared arithmetic unit
// Saturating Q4.28 add and subtract, combinational; a 33 by 33 bit multiply
// whose product is registered, then rounded, shifted and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module luv_alu
  import luv_pkg::*;
(
  input  wire logic        clk_i,
  input  alu_op_e          op_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic        mul_go_i,
  input  wire logic        wb_mul_i,
  output logic      [31:0] res_o
);

  logic signed [32:0] ext_a;
  logic signed [32:0] ext_b;
  logic signed [65:0] prod_q;
  logic               scale_q;
  logic signed [65:0] rounded;
  logic signed [65:0] shifted;
  logic        [32:0] sum;

  // The scale operation takes an unsigned Q0.32 reciprocal as operand b.
  assign ext_a = $signed({a_i[31], a_i});
  assign ext_b = (op_i == ALU_SCALE) ? $signed({1'b0, b_i}) : $signed({b_i[31], b_i});

  always_ff @(posedge clk_i) begin
    if (mul_go_i) begin
      prod_q  <= ext_a * ext_b;
      scale_q <= (op_i == ALU_SCALE);
    end
  end

  always_comb begin
    rounded = prod_q + (scale_q ? 66'sd128 : 66'sd134217728);
    shifted = scale_q ? (rounded >>> 8) : (rounded >>> 28);
    if (op_i == ALU_SUB) begin
      sum = {a_i[31], a_i} - {b_i[31], b_i};
    end else begin
      sum = {a_i[31], a_i} + {b_i[31], b_i};
    end
    res_o = wb_mul_i ? sat66(shifted) : sat33(sum);
  end

endmodule

`default_nettype wire

/* sv/luv_seq.sv */
// ----------------------------------------------------------------------------
// luv_seq: micro-op sequencer
// Steps the program counter through the setup and iteration program, counts
// iterations and decides when the estimate is finished.
// ----------------------------------------------------------------------------
`default_nettype none

module luv_seq
  import luv_pkg::*;
#(
  parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic conv_i,
  input  wire logic out_free_i,
  output luv_ctrl_t ctrl_o
);

  localparam int              ITER_W    = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);

  seq_state_e        state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              conv_q, conv_d;
  uop_t              uop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      pc_q    <= '0;
      iter_q  <= '0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      iter_q  <= iter_d;
      conv_q  <= conv_d;
    end
  end

  assign uop = prog_rom(pc_q);

  always_comb begin
    state_d         = state_q;
    pc_d            = pc_q;
    iter_d          = iter_q;
    conv_d          = conv_q;
    ctrl_o          = '0;
    ctrl_o.busy     = (state_q != SEQ_IDLE);
    ctrl_o.alu_op   = uop.op;
    ctrl_o.src_a    = uop.a;
    ctrl_o.src_b    = uop.b;
    ctrl_o.dst      = uop.dst;
    ctrl_o.out_conv = conv_q;

    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          pc_d    = '0;
          iter_d  = '0;
          state_d = SEQ_ISSUE;
        end
      end
      SEQ_ISSUE: begin
        if (uop.op == ALU_MUL || uop.op == ALU_SCALE) begin
          ctrl_o.mul_go = 1'b1;
          state_d       = SEQ_MUL;
        end else begin
          ctrl_o.we = 1'b1;
          if (pc_q == PROG_LAST) begin
            state_d = SEQ_CHECK;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
      end
      SEQ_MUL: begin
        ctrl_o.we     = 1'b1;
        ctrl_o.wb_mul = 1'b1;
        pc_d          = pc_q + 1'b1;
        state_d       = SEQ_ISSUE;
      end
      SEQ_CHECK: begin
        // The residuals of the iteration just finished sit in dx and dy.
        iter_d = iter_q + 1'b1;
        if (conv_i || iter_q == ITER_LAST) begin
          conv_d  = conv_i;
          state_d = SEQ_DONE;
        end else begin
          pc_d    = PROG_LOOP;
          state_d = SEQ_ISSUE;
        end
      end
      SEQ_DONE: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/lens_undistort_point_unit.sv */
// ----------------------------------------------------------------------------
// lens_undistort_point_unit: iterative lens undistortion of one pixel
// Turns a distorted pixel position into undistorted normalized camera
// coordinates under a five coefficient radial and tangential lens model.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries pixel_u/pixel_v (Q12.4); a transfer happens when
//   in_valid_i is high and in_stall_o is low. The output channel carries
//   norm_x/norm_y (Q4.28) and the converged flag, taken when out_valid_o is
//   high and out_stall_i is low. Registers are written through cfg_we_i,
//   cfg_index_i and cfg_data_i; the user must do so only while no item is in
//   flight, as the block does not enforce it. One item is processed at a time.
//   All arithmetic runs on one shared unit under a micro-op sequencer: an add
//   is written back from the issue state and a multiply from the multiply
//   state, since its product is registered before rounding. Setup shifts and
//   scales the pixel and seeds the estimate; each of 1 to MAX_ITERATIONS
//   iterations runs 14 multiplies, 17 adds and one convergence check.
//   in_stall_o is high from the input transfer until the result is loaded.
//   The result sits in an output register; a stalled receiver holds it there,
//   and the next item may be accepted meanwhile, but its result waits until
//   the register has been taken. Reset empties the output register, returns
//   the sequencer to idle and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module lens_undistort_point_unit
  import luv_pkg::*;
#(
  parameter int MAX_ITERATIONS = DEF_MAX_ITERATIONS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [15:0]           pixel_u_i,
  input  wire logic [15:0]           pixel_v_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [31:0]         norm_x_o,
  output logic signed [31:0]         norm_y_o,
  output logic                       converged_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic signed [31:0] TOL_POS = 32'(TOLERANCE_LSB);
  localparam logic signed [31:0] TOL_NEG = -TOL_POS;

  luv_ctrl_t   ctrl;
  logic [31:0] opa, opb, alu_res;
  logic        in_xfer, out_free, conv;

  // Configuration registers.
  logic [31:0] inv_fx_q, inv_fy_q, k1_q, k2_q, k3_q;
  logic [15:0] cx_q, cy_q;
  logic [63:0] tang_q;

  // Datapath registers.
  logic [15:0] pu_q, pv_q;
  logic [31:0] x_q, y_q, xd_q, yd_q, xx_q, yy_q, r2_q, r4_q, r6_q;
  logic [31:0] xy2_q, rc_q, fx_q, fy_q, t_q, dx_q, dy_q;

  // Output register.
  logic        out_valid_q, conv_out_q;
  logic [31:0] nx_q, ny_q;

  assign in_stall_o = ctrl.busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q <= RST_INV_FOCAL_X;
      inv_fy_q <= RST_INV_FOCAL_Y;
      cx_q     <= RST_CENTER_X;
      cy_q     <= RST_CENTER_Y;
      k1_q     <= '0;
      k2_q     <= '0;
      k3_q     <= '0;
      tang_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_INV_FOCAL_X: inv_fx_q <= cfg_data_i[31:0];
        REG_INV_FOCAL_Y: inv_fy_q <= cfg_data_i[31:0];
        REG_CENTER_X:    cx_q     <= cfg_data_i[15:0];
        REG_CENTER_Y:    cy_q     <= cfg_data_i[15:0];
        REG_RADIAL_K1:   k1_q     <= cfg_data_i[31:0];
        REG_RADIAL_K2:   k2_q     <= cfg_data_i[31:0];
        REG_RADIAL_K3:   k3_q     <= cfg_data_i[31:0];
        REG_TANGENTIAL:  tang_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] opnd_val(input opnd_e sel);
    logic [31:0] v;
    unique case (sel)
      OPD_X:    v = x_q;
      OPD_Y:    v = y_q;
      OPD_XD:   v = xd_q;
      OPD_YD:   v = yd_q;
      OPD_XX:   v = xx_q;
      OPD_YY:   v = yy_q;
      OPD_R2:   v = r2_q;
      OPD_R4:   v = r4_q;
      OPD_R6:   v = r6_q;
      OPD_XY2:  v = xy2_q;
      OPD_RC:   v = rc_q;
      OPD_FX:   v = fx_q;
      OPD_FY:   v = fy_q;
      OPD_T:    v = t_q;
      OPD_DX:   v = dx_q;
      OPD_DY:   v = dy_q;
      OPD_K1:   v = k1_q;
      OPD_K2:   v = k2_q;
      OPD_K3:   v = k3_q;
      OPD_P1:   v = tang_q[31:0];
      OPD_P2:   v = tang_q[63:32];
      OPD_ONE:  v = Q_ONE;
      OPD_ZERO: v = '0;
      OPD_PU:   v = {16'd0, pu_q};
      OPD_PV:   v = {16'd0, pv_q};
      OPD_CX:   v = {16'd0, cx_q};
      OPD_CY:   v = {16'd0, cy_q};
      OPD_IFX:  v = inv_fx_q;
      OPD_IFY:  v = inv_fy_q;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // The operand mux must follow the slot registers as well as the selects.
  always_comb begin
    opa = opnd_val(ctrl.src_a);
    opb = opnd_val(ctrl.src_b);
  end

  luv_alu u_alu (
    .clk_i    (clk_i),
    .op_i     (ctrl.alu_op),
    .a_i      (opa),
    .b_i      (opb),
    .mul_go_i (ctrl.mul_go),
    .wb_mul_i (ctrl.wb_mul),
    .res_o    (alu_res)
  );

  luv_seq #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .conv_i     (conv),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pu_q <= pixel_u_i;
      pv_q <= pixel_v_i;
    end
    if (ctrl.we) begin
      unique case (ctrl.dst)
        OPD_X:   x_q   <= alu_res;
        OPD_Y:   y_q   <= alu_res;
        OPD_XD:  xd_q  <= alu_res;
        OPD_YD:  yd_q  <= alu_res;
        OPD_XX:  xx_q  <= alu_res;
        OPD_YY:  yy_q  <= alu_res;
        OPD_R2:  r2_q  <= alu_res;
        OPD_R4:  r4_q  <= alu_res;
        OPD_R6:  r6_q  <= alu_res;
        OPD_XY2: xy2_q <= alu_res;
        OPD_RC:  rc_q  <= alu_res;
        OPD_FX:  fx_q  <= alu_res;
        OPD_FY:  fy_q  <= alu_res;
        OPD_T:   t_q   <= alu_res;
        OPD_DX:  dx_q  <= alu_res;
        OPD_DY:  dy_q  <= alu_res;
        default: ;
      endcase
    end
  end

  // Both residual magnitudes strictly below the tolerance; a zero tolerance
  // never passes.
  assign conv = ($signed(dx_q) < TOL_POS) && ($signed(dx_q) > TOL_NEG) &&
                ($signed(dy_q) < TOL_POS) && ($signed(dy_q) > TOL_NEG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      nx_q       <= x_q;
      ny_q       <= y_q;
      conv_out_q <= ctrl.out_conv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign norm_x_o    = $signed(nx_q);
  assign norm_y_o    = $signed(ny_q);
  assign converged_o = conv_out_q;

  // A result is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending transfer");

  // A multiply writeback always follows the cycle that captured its product.
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wb_mul |-> $past(ctrl.mul_go))
    else $error("multiply writeback without a captured product");

  // After an input transfer the unit is busy and no result appears at once.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (in_stall_o && !ctrl.out_load))
    else $error("unit not busy after input transfer");

  // A converged result is only reported while the residuals meet tolerance.
  a_conv_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.out_load && ctrl.out_conv) |-> conv)
    else $error("converged flag without residuals in tolerance");

endmodule

`default_nettype wire
